>>> sv/crcrs_pkg.sv
// shared types, constants and the byte lookup table for the seeded crc-32 block
package crcrs_pkg;

    // reflected form of generator polynomial 0x04C11DB7
    localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;
    // palette mode uses group positions below this value
    localparam logic [2:0] PALETTE_USED = 3'd2;

    // one accepted input transaction
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] seed;
        logic        first;
        logic        last;
        logic        mode;
    } t_item;

    // handshake between the input register and the update stage
    typedef struct packed {
        logic valid;
    } t_stage_ctl;

    // one table entry, worked out bit by bit; over an 8-bit index this is the
    // fixed 256-entry lookup as plain logic
    function automatic logic [31:0] f_lut_entry(input logic [7:0] idx);
        logic [31:0] val;
        val = {24'd0, idx};
        for (int k = 0; k < 8; k++) begin
            if (val[0]) begin
                val = (val >> 1) ^ POLY_REFLECTED;
            end else begin
                val = val >> 1;
            end
        end
        return val;
    endfunction

endpackage

>>> sv/crc32_reflected_seeded.sv
// top level of the seeded reflected crc-32 byte stream block
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | i_valid, o_stall, i_data_byte, i_seed, i_first,  | in
//          | i_last, i_mode                                  |
//  result  | o_valid, i_stall, o_checksum                    | out
//
// one byte per cycle sustained unless a last byte waits on a held result; a byte is
// taken into the input register, and from there a single table lookup and xor
// update the crc state. a checksum is registered in the result register as its last
// byte leaves the input register. synchronous active-low reset clears the crc,
// seed, phase and mode state and both valid flags. while a result is held
// under stall, bytes without last keep flowing; a last byte waits.
module crc32_reflected_seeded (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_seed,
    input  logic        i_first,
    input  logic        i_last,
    input  logic        i_mode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_checksum
);

    crcrs_pkg::t_item      in_item;
    crcrs_pkg::t_item      s1_item;
    crcrs_pkg::t_stage_ctl s1_ctl;
    logic                  s1_go;

    // gather the input transaction
    assign in_item.data_byte = i_data_byte;
    assign in_item.seed      = i_seed;
    assign in_item.first     = i_first;
    assign in_item.last      = i_last;
    assign in_item.mode      = i_mode;

    crcrs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_go    (s1_go),
        .o_ctl   (s1_ctl),
        .o_item  (s1_item)
    );

    crcrs_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (s1_ctl),
        .i_item     (s1_item),
        .i_stall    (i_stall),
        .o_go       (s1_go),
        .o_valid    (o_valid),
        .o_checksum (o_checksum)
    );

endmodule

>>> sv/crcrs_in_stage.sv
// input register stage: holds one transaction until the update stage takes it
module crcrs_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  crcrs_pkg::t_item     i_item,
    input  logic                 i_go,
    output crcrs_pkg::t_stage_ctl o_ctl,
    output crcrs_pkg::t_item     o_item
);

    logic             r_valid;
    logic             n_valid;
    crcrs_pkg::t_item r_item;
    logic             take;

    // room when empty or when the held transaction moves on this cycle
    assign o_stall = r_valid && !i_go;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_item      = r_item;

endmodule

>>> sv/crcrs_engine.sv
// crc state, one-byte table update and result register
module crcrs_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crcrs_pkg::t_stage_ctl i_ctl,
    input  crcrs_pkg::t_item      i_item,
    input  logic                  i_stall,
    output logic                  o_go,
    output logic                  o_valid,
    output logic [31:0]           o_checksum
);

    logic [31:0] r_crc;
    logic [31:0] r_seed;
    logic [2:0]  r_phase;
    logic        r_mode;
    logic        r_out_valid;
    logic [31:0] r_out_checksum;

    logic [31:0] base_crc;
    logic [31:0] base_seed;
    logic [2:0]  base_phase;
    logic        base_mode;
    logic        use_byte;
    logic [7:0]  lut_idx;
    logic [31:0] upd_crc;
    logic [31:0] n_crc;
    logic        out_free;

    // a transaction without last never needs the result register
    assign out_free = !r_out_valid || !i_stall;
    assign o_go     = i_ctl.valid && (!i_item.last || out_free);

    // start of message loads seed and mode
    assign base_crc   = i_item.first ? i_item.seed : r_crc;
    assign base_seed  = i_item.first ? i_item.seed : r_seed;
    assign base_mode  = i_item.first ? i_item.mode : r_mode;
    assign base_phase = i_item.first ? 3'd0 : r_phase;

    // palette mode skips group positions two through seven
    assign use_byte = !base_mode || (base_phase < crcrs_pkg::PALETTE_USED);
    assign lut_idx  = base_crc[7:0] ^ i_item.data_byte;
    assign upd_crc  = (base_crc >> 8) ^ crcrs_pkg::f_lut_entry(lut_idx);
    assign n_crc    = use_byte ? upd_crc : base_crc;

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_seed  <= '0;
            r_phase <= '0;
            r_mode  <= 1'b0;
        end else if (o_go) begin
            r_crc   <= n_crc;
            r_seed  <= base_seed;
            r_phase <= base_phase + 3'd1;
            r_mode  <= base_mode;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_go && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_go && i_item.last) begin
            r_out_checksum <= n_crc ^ base_seed;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_out_checksum;

endmodule

>>> sv/crcrs_checker.sv
// port-level checks for the seeded crc-32 block and their bind
module crcrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_checksum
);

    // reset empties both registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("valid or stall high after reset");

    // input side only waits behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled with result path free");

    // held result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

    // held checksum does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_checksum))
        else $error("checksum changed under stall");

endmodule

bind crc32_reflected_seeded crcrs_checker u_crcrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_checksum (o_checksum)
);

>>> bench/tb.sv
// self-checking testbench for the seeded reflected crc-32 byte stream block
`timescale 1ns / 1ps

module tb;

    localparam logic [31:0] REFL_POLY   = 32'hEDB8_8320;
    localparam int unsigned RANDOM_ITEMS = 750;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // expected checksums worked out from the accepted byte stream
    class crc_scoreboard;
        bit [31:0] running;
        bit [31:0] seed_latch;
        bit [2:0]  phase;
        bit        palette;
        bit [31:0] checksum_q[$];
        int        mismatches;

        function new();
            running    = '0;
            seed_latch = '0;
            phase      = '0;
            palette    = 1'b0;
            mismatches = 0;
        endfunction

        // one byte through the reflected polynomial, lsb first
        function bit [31:0] crc_update(bit [31:0] crc, bit [7:0] b);
            bit [31:0] acc;
            acc = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++) begin
                if (acc[0]) begin
                    acc = (acc >> 1) ^ REFL_POLY;
                end else begin
                    acc = acc >> 1;
                end
            end
            return acc;
        endfunction

        // accepted input transaction
        function void note_byte(bit [7:0] b, bit [31:0] s, bit f, bit l, bit m);
            if (f) begin
                running    = s;
                seed_latch = s;
                palette    = m;
                phase      = '0;
            end
            if (!palette || phase < crcrs_pkg::PALETTE_USED) begin
                running = crc_update(running, b);
            end
            phase = phase + 3'd1;
            if (l) begin
                checksum_q.push_back(running ^ seed_latch);
            end
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_checksum(bit [31:0] got);
            bit [31:0] want;
            if (checksum_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected checksum %08h", got);
                end
                mismatches++;
                return;
            end
            want = checksum_q.pop_front();
            if (got !== want) begin
                if (mismatches < 10) begin
                    $display("checksum mismatch: expected %08h got %08h", want, got);
                end
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return checksum_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic [31:0] i_seed;
    logic        i_first;
    logic        i_last;
    logic        i_mode;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_checksum;

    crc_scoreboard sb = new();

    int unsigned cycles     = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;

    crc32_reflected_seeded dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_seed      (i_seed),
        .i_first     (i_first),
        .i_last      (i_last),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_checksum  (o_checksum)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[crc32_reflected_seeded] ERROR");
            $finish;
        end
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_checksum(o_checksum);
            end
            if (i_valid && !o_stall) begin
                sb.note_byte(i_data_byte, i_seed, i_first, i_last, i_mode);
            end
        end
    end

    // receiver stall pattern: calm, coin flip, or long runs, switching now and then
    int unsigned stall_style = 0;
    int unsigned stall_run   = 0;
    always @(negedge i_clk) begin
        if (cycles % 173 == 0) begin
            stall_style <= $urandom_range(0, 2);
        end
        case (stall_style)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (stall_run == 0) begin
                    stall_run <= $urandom_range(1, 12);
                    i_stall   <= ~i_stall;
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    // one input transaction, with a random gap before each burst
    task automatic send_byte(input logic [7:0] b, input logic [31:0] s,
                             input logic f, input logic l, input logic m);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                i_valid     <= 1'b0;
                i_data_byte <= 8'($urandom);
                i_seed      <= $urandom;
                i_first     <= 1'($urandom_range(0, 1));
                i_last      <= 1'($urandom_range(0, 1));
                i_mode      <= 1'($urandom_range(0, 1));
                @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_seed      <= s;
        i_first     <= f;
        i_last      <= l;
        i_mode      <= m;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // well-formed message; seed and mode on later bytes are noise
    task automatic send_message(input int unsigned len, input logic [31:0] s,
                                input logic m);
        for (int unsigned n = 0; n < len; n++) begin
            if (n == 0) begin
                send_byte(8'($urandom), s, 1'b1, len == 1, m);
            end else begin
                send_byte(8'($urandom), $urandom, 1'b0, n == len - 1,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned len;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_seed      = '0;
        i_first     = 1'b0;
        i_last      = 1'b0;
        i_mode      = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes with no first since reset continue from the cleared state
        send_byte(8'hA5, 32'h1234_5678, 1'b0, 1'b0, 1'b1);
        send_byte(8'h3C, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
        // one-byte messages at the field extremes
        send_byte(8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0);
        send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        // all-bytes mode, extreme bytes
        send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        send_byte(8'hFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        send_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
        // palette mode, last lands on a skipped position of the second group
        for (int n = 0; n < 11; n++) begin
            send_byte(8'(n * 37 + 1), (n == 0) ? 32'hDEAD_BEEF : 32'h0,
                      n == 0, n == 10, n == 0);
        end
        // no first since a result: state carries on
        send_byte(8'h5A, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_byte(8'hC3, 32'h0000_0000, 1'b0, 1'b1, 1'b1);

        // random part: mostly well-formed messages, some noise transactions
        while (bytes_sent < RANDOM_ITEMS + 21) begin
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                send_message(len, pick_seed(), 1'($urandom_range(0, 1)));
            end else begin
                send_byte(8'($urandom), pick_seed(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        i_valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[crc32_reflected_seeded] OK");
        end else begin
            $display("[crc32_reflected_seeded] ERROR");
        end
        $finish;
    end

endmodule
